@@ hdl/sld_pkg.sv @@
// shared types, constants and transition functions of the script lexer
// no dependencies
package sld_pkg;

  localparam logic [2:0] EV_IMAGE   = 3'd0;
  localparam logic [2:0] EV_TOKEN   = 3'd1;
  localparam logic [2:0] EV_INVALID = 3'd2;
  localparam logic [2:0] EV_STOP    = 3'd3;
  localparam logic [2:0] EV_UNEXP   = 3'd4;

  localparam logic [4:0] TK_NONE = 5'd23;
  localparam logic [6:0] ST_ENTRY = 7'd0;

  localparam logic [7:0] F_ACC  = 8'h20;
  localparam logic [7:0] F_IGN  = 8'h40;
  localparam logic [7:0] F_STOP = 8'h80;

  typedef struct packed {
    logic       tok_end;   // pending token ends before this byte
    logic       has_ev;    // image byte or invalid character
    logic [2:0] ev_kind;
    logic       stop;
    logic [4:0] tok_kind;  // kind of the ending token
    logic [6:0] state;     // state after the item
    logic       img;       // image nonempty after the item
  } step_t;

  function automatic logic [7:0] st_attr(input logic [6:0] s);
    logic [7:0] a;
    a = {3'b000, TK_NONE};
    case (s)
      7'd0: a = {3'b000, TK_NONE};
      7'd13: a = F_ACC | 8'd1;
      7'd14: a = F_ACC | 8'd2;
      7'd15: a = F_ACC | 8'd3;
      7'd16: a = F_ACC | 8'd4;
      7'd17: a = F_ACC | 8'd5;
      7'd18: a = F_ACC | 8'd6;
      7'd19: a = F_ACC | 8'd7;
      7'd20: a = F_ACC | 8'd8;
      7'd30, 7'd31: a = F_ACC | 8'd9;
      7'd32, 7'd39: a = F_ACC | 8'd10;
      7'd33, 7'd62: a = F_ACC | 8'd14;
      7'd40, 7'd44: a = F_ACC | 8'd11;
      7'd45, 7'd47: a = F_ACC | 8'd12;
      7'd48, 7'd53: a = F_ACC | 8'd13;
      7'd54: a = F_ACC | 8'd15;
      7'd63, 7'd74: a = F_IGN | {3'b000, TK_NONE};
      7'd64: a = F_ACC | 8'd16;
      7'd65: a = F_ACC | 8'd17;
      7'd66, 7'd67, 7'd69: a = F_ACC | 8'd18;
      7'd68, 7'd77: a = F_ACC;
      7'd70, 7'd72, 7'd81, 7'd82: a = 8'd19;
      7'd71, 7'd73: a = F_ACC | 8'd19;
      7'd75: a = F_IGN | F_STOP | {3'b000, TK_NONE};
      7'd76: a = F_STOP | F_ACC | 8'd20;
      7'd78, 7'd79: a = 8'd21;
      7'd80: a = F_ACC | 8'd21;
      7'd83, 7'd84, 7'd85, 7'd87, 7'd88, 7'd89, 7'd90, 7'd92: a = 8'd22;
      7'd86, 7'd91: a = F_ACC | 8'd22;
      default: begin
        if (s >= 7'd1 && s <= 7'd12) a = F_ACC;
        else if (s >= 7'd21 && s <= 7'd29) a = F_ACC;
        else a = {3'b000, TK_NONE};
      end
    endcase
    return a;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0d;
  endfunction

  // triple-quote body: body, one quote, two quotes, done, escape
  function automatic logic [7:0] triple_next(input logic [6:0] s, input logic [7:0] b,
                                             input logic [6:0] base, input logic [7:0] q);
    logic [6:0] k;
    k = s - base;
    if (k == 7'd3) return 8'd0;
    if (k == 7'd4) return {1'b1, base};
    if (b == "\\") return {1'b1, base + 7'd4};
    if (b == q) return {1'b1, s + 7'd1};
    return {1'b1, base};
  endfunction

  // returns {valid, next state}
  function automatic logic [7:0] next_state(input logic [6:0] s, input logic [7:0] b);
    logic [7:0] r;
    r = 8'd0;
    case (s)
      7'd0: begin
        case (b)
          "-": r = {1'b1, 7'd1};   "+": r = {1'b1, 7'd2};
          "*": r = {1'b1, 7'd3};   "%": r = {1'b1, 7'd4};
          "!": r = {1'b1, 7'd5};   "=": r = {1'b1, 7'd6};
          "<": r = {1'b1, 7'd7};   ">": r = {1'b1, 7'd8};
          "|": r = {1'b1, 7'd9};   "~": r = {1'b1, 7'd10};
          "&": r = {1'b1, 7'd11};  "^": r = {1'b1, 7'd12};
          ":": r = {1'b1, 7'd13};  ",": r = {1'b1, 7'd14};
          "(": r = {1'b1, 7'd15};  ")": r = {1'b1, 7'd16};
          "[": r = {1'b1, 7'd17};  "]": r = {1'b1, 7'd18};
          "{": r = {1'b1, 7'd19};  "}": r = {1'b1, 7'd20};
          "$": r = {1'b1, 7'd32};  ".": r = {1'b1, 7'd68};
          "'": r = {1'b1, 7'd70};  "\"": r = {1'b1, 7'd72};
          "#": r = {1'b1, 7'd74};  8'h0a: r = {1'b1, 7'd76};
          "/": r = {1'b1, 7'd77};
          default: begin
            if (is_blank(b)) r = {1'b1, 7'd63};
            else if (is_letter(b) || b == "_") r = {1'b1, 7'd64};
            else if (is_digit(b)) r = {1'b1, 7'd65};
          end
        endcase
      end
      7'd2:  if (b == "+") r = {1'b1, 7'd21};
      7'd4:  if (b == "%") r = {1'b1, 7'd54};
      7'd5:  if (b == "=") r = {1'b1, 7'd27};
      7'd7:  begin
        if (b == "<") r = {1'b1, 7'd22};
        else if (b == "=") r = {1'b1, 7'd25};
      end
      7'd8:  begin
        if (b == ">") r = {1'b1, 7'd23};
        else if (b == "=") r = {1'b1, 7'd26};
      end
      7'd9:  begin
        if (b == "|") r = {1'b1, 7'd28};
        else if (b == ":") r = {1'b1, 7'd30};
        else if (b == "?") r = {1'b1, 7'd31};
      end
      7'd11: if (b == "&") r = {1'b1, 7'd29};
      7'd23: if (b == ">") r = {1'b1, 7'd24};
      7'd32: begin
        if (b == "e") r = {1'b1, 7'd33};
        else if (b == "i") r = {1'b1, 7'd40};
        else if (b == "k") r = {1'b1, 7'd45};
        else if (b == "r") r = {1'b1, 7'd48};
      end
      7'd33: begin
        if (b == "l") r = {1'b1, 7'd34};
        else if (b == "x") r = {1'b1, 7'd55};
      end
      7'd34: if (b == "e") r = {1'b1, 7'd35};
      7'd35: if (b == "m") r = {1'b1, 7'd36};
      7'd36: if (b == "e") r = {1'b1, 7'd37};
      7'd37: if (b == "n") r = {1'b1, 7'd38};
      7'd38: if (b == "t") r = {1'b1, 7'd39};
      7'd40: if (b == "n") r = {1'b1, 7'd41};
      7'd41: if (b == "d") r = {1'b1, 7'd42};
      7'd42: if (b == "e") r = {1'b1, 7'd43};
      7'd43: if (b == "x") r = {1'b1, 7'd44};
      7'd45: if (b == "e") r = {1'b1, 7'd46};
      7'd46: if (b == "y") r = {1'b1, 7'd47};
      7'd48: if (b == "e") r = {1'b1, 7'd49};
      7'd49: if (b == "s") r = {1'b1, 7'd50};
      7'd50: if (b == "u") r = {1'b1, 7'd51};
      7'd51: if (b == "l") r = {1'b1, 7'd52};
      7'd52: if (b == "t") r = {1'b1, 7'd53};
      7'd55: if (b == "c") r = {1'b1, 7'd56};
      7'd56: if (b == "e") r = {1'b1, 7'd57};
      7'd57: if (b == "p") r = {1'b1, 7'd58};
      7'd58: if (b == "t") r = {1'b1, 7'd59};
      7'd59: if (b == "i") r = {1'b1, 7'd60};
      7'd60: if (b == "o") r = {1'b1, 7'd61};
      7'd61: if (b == "n") r = {1'b1, 7'd62};
      7'd63: if (is_blank(b)) r = {1'b1, 7'd63};
      7'd64: if (is_letter(b) || b == "_" || is_digit(b)) r = {1'b1, 7'd64};
      7'd65: begin
        if (is_digit(b) || b == "_") r = {1'b1, 7'd65};
        else if (b == ".") r = {1'b1, 7'd66};
      end
      7'd66: if (is_digit(b)) r = {1'b1, 7'd67};
      7'd67: if (is_digit(b) || b == "_") r = {1'b1, 7'd67};
      7'd68: if (is_digit(b)) r = {1'b1, 7'd69};
      7'd69: if (is_digit(b) || b == "_") r = {1'b1, 7'd69};
      7'd70: r = (b == "\\") ? {1'b1, 7'd81} : (b == "'") ? {1'b1, 7'd71} : {1'b1, 7'd70};
      7'd71: if (b == "'") r = {1'b1, 7'd83};
      7'd81: r = {1'b1, 7'd70};
      7'd72: r = (b == "\\") ? {1'b1, 7'd82} : (b == "\"") ? {1'b1, 7'd73} : {1'b1, 7'd72};
      7'd73: if (b == "\"") r = {1'b1, 7'd88};
      7'd82: r = {1'b1, 7'd72};
      7'd74: r = (b == 8'h0a) ? {1'b1, 7'd75} : {1'b1, 7'd74};
      7'd77: begin
        if (b == "/") r = {1'b1, 7'd80};
        else if (b == "\\") r = {1'b1, 7'd79};
        else if (!(is_blank(b) || b == 8'h0a)) r = {1'b1, 7'd78};
      end
      7'd78: begin
        if (b == "\\") r = {1'b1, 7'd79};
        else if (b == "/") r = {1'b1, 7'd80};
        else if (b != 8'h0a) r = {1'b1, 7'd78};
      end
      7'd79: r = {1'b1, 7'd78};
      7'd80: if (is_letter(b)) r = {1'b1, 7'd80};
      default: begin
        if (s >= 7'd83 && s <= 7'd87) r = triple_next(s, b, 7'd83, "'");
        else if (s >= 7'd88 && s <= 7'd92) r = triple_next(s, b, 7'd88, "\"");
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/script_lexer_dfa.sv @@
// top level of the script lexer: state registers, line tracking, result queue
// depends on sld_pkg and sld_step
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: char_in; tuser: end_of_text
// m_*      out  m_tvalid/m_tready  tdata: char_out, token_kind, line_number;
//                                  tuser: event_kind; tlast: last_event
// cfg_*    in   cfg_valid/ready    cfg_data: first_line
//
// one byte is taken per cycle, giving zero to three results into an 8-entry queue
// results leave at one per cycle while m_tready is high; input stalls while fewer than three entries are free
// the lexer state updates in the cycle of the input transaction
// cfg_ready is low while an input byte is offered
// rst clears the state, the line counter and the queue; first_line returns to 1
module script_lexer_dfa #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tuser,   // [0] end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] char_out, [12:8] token_kind, [28:13] line_number
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  output logic        m_tlast,   // last_event
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // first_line
);
  import sld_pkg::*;

  localparam int SUM_BITS = ((LINE_BITS > 16) ? LINE_BITS : 16) + 1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam int DEPTH = 8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic [4:0]  tk;
    logic [15:0] line;
    logic        last;
  } ev_t;

  logic [15:0]          first_line;
  logic [6:0]           state;
  logic [LINE_BITS-1:0] nl_count, nl_next, token_line;
  logic                 img;
  step_t                step;
  ev_t                  q [DEPTH];
  ev_t                  ev [3];
  logic [1:0]           n_ev;
  logic [2:0]           head, tail;
  logic [3:0]           count, count_next;
  logic                 acc, pop;
  logic [LINE_BITS-1:0] tl1, line_now, line_nl;

  function automatic logic [LINE_BITS-1:0] line_of(input logic [15:0] fl,
                                                   input logic [LINE_BITS-1:0] c);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(fl) + SUM_BITS'(c);
    return (s > SUM_BITS'(LINE_MAX)) ? LINE_MAX : s[LINE_BITS-1:0];
  endfunction

  function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] l);
    logic [SUM_BITS-1:0] w;
    w = SUM_BITS'(l);
    return w[15:0];
  endfunction

  sld_step u_step (
    .state       (state),
    .img         (img),
    .char_in     (s_tdata),
    .end_of_text (s_tuser),
    .step        (step)
  );

  assign acc       = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;
  assign s_tready  = count <= 4'(DEPTH - 3);
  assign cfg_ready = !s_tvalid;
  assign m_tvalid  = count != 4'd0;
  assign m_tuser   = q[head].kind;
  assign m_tlast   = q[head].last;
  assign m_tdata   = {3'b000, q[head].line, q[head].tk, q[head].ch};

  always_comb begin
    line_now = line_of(first_line, nl_count);
    tl1      = step.tok_end ? line_now : token_line;
    nl_next  = (s_tdata == 8'h0a && nl_count < LINE_MAX) ? nl_count + 1'b1 : nl_count;
    line_nl  = line_of(first_line, nl_next);

    for (int i = 0; i < 3; i++) ev[i] = '0;
    n_ev = 2'd0;
    if (s_tuser) begin
      ev[0] = '{kind: step.ev_kind, ch: 8'd0, tk: step.tok_kind,
                line: line16(token_line), last: 1'b1};
      n_ev = step.has_ev ? 2'd1 : 2'd0;
    end else begin
      // token end, then image or invalid, then stop
      if (step.tok_end) begin
        ev[n_ev] = '{kind: EV_TOKEN, ch: 8'd0, tk: step.tok_kind,
                     line: line16(token_line), last: 1'b0};
        n_ev = n_ev + 2'd1;
      end
      if (step.has_ev) begin
        ev[n_ev] = '{kind: step.ev_kind, ch: s_tdata, tk: TK_NONE,
                     line: line16(tl1), last: 1'b0};
        n_ev = n_ev + 2'd1;
      end
      if (step.stop) begin
        ev[n_ev] = '{kind: EV_STOP, ch: 8'd0, tk: TK_NONE,
                     line: line16(tl1), last: 1'b0};
        n_ev = n_ev + 2'd1;
      end
      if (n_ev != 2'd0) ev[n_ev - 2'd1].last = 1'b1;
    end
    count_next = count + (acc ? {2'b00, n_ev} : 4'd0) - (pop ? 4'd1 : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line <= 16'd1;
      state      <= ST_ENTRY;
      nl_count   <= '0;
      token_line <= LINE_BITS'(1);
      img        <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
    end else begin
      if (acc) begin
        state <= step.state;
        img   <= step.img;
        if (s_tuser) begin
          nl_count   <= '0;
          token_line <= line_of(first_line, '0);
        end else begin
          nl_count   <= nl_next;
          token_line <= step.stop ? line_nl : tl1;
        end
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < n_ev) q[tail + 3'(i)] <= ev[i];
        end
        tail <= tail + {1'b0, n_ev};
      end else if (cfg_valid && cfg_ready) begin
        first_line <= cfg_data;
        if (state == ST_ENTRY) token_line <= line_of(cfg_data, nl_count);
      end
      if (pop) head <= head + 3'd1;
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 4'(DEPTH))
    else $error("result queue overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (tail - head) == count[2:0])
    else $error("queue pointers disagree with count");
  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENTRY) |-> !img)
    else $error("image pending in entry state");
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && s_tuser) |=> (state == ST_ENTRY && nl_count == '0))
    else $error("end of text did not reset the lexer");
`endif

endmodule

@@ hdl/sld_step.sv @@
// next-state and event selection for one byte of the lexer
// depends on sld_pkg
module sld_step (
  input  logic [6:0]    state,
  input  logic          img,
  input  logic [7:0]    char_in,
  input  logic          end_of_text,
  output sld_pkg::step_t step
);
  import sld_pkg::*;

  logic [7:0] attr, nx, nx0, fin, attr_fin, attr_st1;
  logic       restart;
  logic [6:0] st1;
  logic       img1;

  always_comb begin
    attr     = st_attr(state);
    nx       = next_state(state, char_in);
    nx0      = next_state(ST_ENTRY, char_in);
    restart  = !nx[7] && ((attr & (F_ACC | F_IGN)) != 8'd0);
    fin      = restart ? nx0 : nx;
    attr_fin = st_attr(fin[6:0]);
    st1      = fin[7] ? fin[6:0] : (restart ? ST_ENTRY : state);
    img1     = (fin[7] && (attr_fin & F_IGN) == 8'd0) ? 1'b1 : (restart ? 1'b0 : img);
    attr_st1 = st_attr(st1);

    step = '0;
    step.tok_kind = attr[4:0];
    if (end_of_text) begin
      // flush the pending image
      step.has_ev  = img;
      step.ev_kind = ((attr & F_ACC) != 8'd0) ? EV_TOKEN : EV_UNEXP;
      step.state   = ST_ENTRY;
      step.img     = 1'b0;
    end else begin
      step.tok_end = restart && ((attr & F_ACC) != 8'd0);
      step.has_ev  = !fin[7] || ((attr_fin & F_IGN) == 8'd0);
      step.ev_kind = fin[7] ? EV_IMAGE : EV_INVALID;
      step.stop    = (attr_st1 & F_STOP) != 8'd0;
      step.state   = step.stop ? ST_ENTRY : st1;
      step.img     = step.stop ? 1'b0 : img1;
    end
  end

endmodule

@@ dv/tb_script_lexer_dfa.sv @@
// self-checking bench for script_lexer_dfa: byte stream in, lexer events out
// keeps its own copy of the lexer state machine and checks every event against it
// depends on sld_pkg (event codes, none kind) and the script_lexer_dfa rtl
`timescale 1ns / 1ps

module tb_script_lexer_dfa;
  import sld_pkg::*;

  localparam logic [7:0] A_ACC  = 8'h20;
  localparam logic [7:0] A_IGN  = 8'h40;
  localparam logic [7:0] A_STOP = 8'h80;
  localparam logic [7:0] A_NONE = 8'd23;
  localparam int unsigned LMAX = 65535;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic [4:0]  tk;
    logic [15:0] line;
    logic        last;
  } lex_event_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 0;

  lex_event_t event_q[$];
  int errors = 0;
  int items_sent = 0;
  int events_seen = 0;
  int hold_req = 0;
  bit no_idle = 0;

  // mirror of the lexer state
  logic [6:0]  mir_state;
  int unsigned mir_nl;
  logic [15:0] mir_tok_line;
  logic        mir_img;
  logic [15:0] mir_first;

  script_lexer_dfa DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] line_at(int unsigned cnt);
    int unsigned s;
    s = mir_first + cnt;
    return (s > LMAX) ? 16'(LMAX) : 16'(s);
  endfunction

  function automatic logic [7:0] state_flags(logic [6:0] s);
    if (s == 0) return A_NONE;
    if (s <= 12 || (s >= 21 && s <= 29) || s == 68 || s == 77) return A_ACC;
    if (s <= 20) return A_ACC | 8'(s - 12);
    if (s == 30 || s == 31) return A_ACC | 8'd9;
    if (s == 32 || s == 39) return A_ACC | 8'd10;
    if (s == 33 || s == 62) return A_ACC | 8'd14;
    if (s == 40 || s == 44) return A_ACC | 8'd11;
    if (s == 45 || s == 47) return A_ACC | 8'd12;
    if (s == 48 || s == 53) return A_ACC | 8'd13;
    if (s == 54) return A_ACC | 8'd15;
    if (s == 63 || s == 74) return A_IGN | A_NONE;
    if (s == 64) return A_ACC | 8'd16;
    if (s == 65) return A_ACC | 8'd17;
    if (s == 66 || s == 67 || s == 69) return A_ACC | 8'd18;
    if (s == 70 || s == 72 || s == 81 || s == 82) return 8'd19;
    if (s == 71 || s == 73) return A_ACC | 8'd19;
    if (s == 75) return A_IGN | A_STOP | A_NONE;
    if (s == 76) return A_STOP | A_ACC | 8'd20;
    if (s == 78 || s == 79) return 8'd21;
    if (s == 80) return A_ACC | 8'd21;
    if (s == 86 || s == 91) return A_ACC | 8'd22;
    if (s >= 83 && s <= 92) return 8'd22;
    return A_NONE;
  endfunction

  function automatic bit blank(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0d;
  endfunction
  function automatic bit alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // -1 when the state has no move on this byte
  function automatic int move(logic [6:0] s, logic [7:0] b);
    int base;
    case (s)
      0: begin
        case (b)
          "-": return 1;  "+": return 2;  "*": return 3;  "%": return 4;
          "!": return 5;  "=": return 6;  "<": return 7;  ">": return 8;
          "|": return 9;  "~": return 10; "&": return 11; "^": return 12;
          ":": return 13; ",": return 14; "(": return 15; ")": return 16;
          "[": return 17; "]": return 18; "{": return 19; "}": return 20;
          "$": return 32; ".": return 68; "'": return 70; "\"": return 72;
          "#": return 74; 8'h0a: return 76; "/": return 77;
          default: begin
            if (blank(b)) return 63;
            if (alpha(b) || b == "_") return 64;
            if (num(b)) return 65;
            return -1;
          end
        endcase
      end
      2: return b == "+" ? 21 : -1;
      4: return b == "%" ? 54 : -1;
      5: return b == "=" ? 27 : -1;
      7: return b == "<" ? 22 : (b == "=" ? 25 : -1);
      8: return b == ">" ? 23 : (b == "=" ? 26 : -1);
      9: return b == "|" ? 28 : (b == ":" ? 30 : (b == "?" ? 31 : -1));
      11: return b == "&" ? 29 : -1;
      23: return b == ">" ? 24 : -1;
      32: return b == "e" ? 33 : b == "i" ? 40 : b == "k" ? 45 : b == "r" ? 48 : -1;
      33: return b == "l" ? 34 : (b == "x" ? 55 : -1);
      34: return b == "e" ? 35 : -1;
      35: return b == "m" ? 36 : -1;
      36: return b == "e" ? 37 : -1;
      37: return b == "n" ? 38 : -1;
      38: return b == "t" ? 39 : -1;
      40: return b == "n" ? 41 : -1;
      41: return b == "d" ? 42 : -1;
      42: return b == "e" ? 43 : -1;
      43: return b == "x" ? 44 : -1;
      45: return b == "e" ? 46 : -1;
      46: return b == "y" ? 47 : -1;
      48: return b == "e" ? 49 : -1;
      49: return b == "s" ? 50 : -1;
      50: return b == "u" ? 51 : -1;
      51: return b == "l" ? 52 : -1;
      52: return b == "t" ? 53 : -1;
      55: return b == "c" ? 56 : -1;
      56: return b == "e" ? 57 : -1;
      57: return b == "p" ? 58 : -1;
      58: return b == "t" ? 59 : -1;
      59: return b == "i" ? 60 : -1;
      60: return b == "o" ? 61 : -1;
      61: return b == "n" ? 62 : -1;
      63: return blank(b) ? 63 : -1;
      64: return (alpha(b) || b == "_" || num(b)) ? 64 : -1;
      65: return (num(b) || b == "_") ? 65 : (b == "." ? 66 : -1);
      66: return num(b) ? 67 : -1;
      67, 69: return (num(b) || b == "_") ? int'(s) : -1;
      68: return num(b) ? 69 : -1;
      70: return b == "\\" ? 81 : (b == "'" ? 71 : 70);
      71: return b == "'" ? 83 : -1;
      81: return 70;
      72: return b == "\\" ? 82 : (b == "\"" ? 73 : 72);
      73: return b == "\"" ? 88 : -1;
      82: return 72;
      74: return b == 8'h0a ? 75 : 74;
      77: begin
        if (b == "/") return 80;
        if (b == "\\") return 79;
        return (blank(b) || b == 8'h0a) ? -1 : 78;
      end
      78: return b == "\\" ? 79 : (b == "/" ? 80 : (b == 8'h0a ? -1 : 78));
      79: return 78;
      80: return alpha(b) ? 80 : -1;
      default: begin
        if (s >= 83 && s <= 92) begin
          base = (s >= 88) ? 88 : 83;
          if (s - base == 3) return -1;
          if (s - base == 4) return base;
          if (b == "\\") return base + 4;
          if (b == ((base == 88) ? "\"" : "'")) return s + 1;
          return base;
        end
        return -1;
      end
    endcase
  endfunction

  task automatic add_event(logic [2:0] k, logic [7:0] c, logic [4:0] t, logic [15:0] l);
    lex_event_t e;
    e.kind = k; e.ch = c; e.tk = t; e.line = l; e.last = 1'b0;
    event_q = {event_q, e};
  endtask

  task automatic lex_predict(logic [7:0] b, logic eot);
    logic [7:0] fl;
    int nx;
    int n_prior;
    n_prior = event_q.size();
    fl = state_flags(mir_state);
    if (eot) begin
      if (mir_img)
        add_event((fl & A_ACC) ? EV_TOKEN : EV_UNEXP, 8'h00, fl[4:0], mir_tok_line);
      mir_state = '0; mir_img = 1'b0; mir_nl = 0;
      mir_tok_line = line_at(0);
    end else begin
      nx = move(mir_state, b);
      if (nx < 0 && (fl & (A_ACC | A_IGN))) begin
        if (fl & A_ACC) begin
          add_event(EV_TOKEN, 8'h00, fl[4:0], mir_tok_line);
          mir_tok_line = line_at(mir_nl);
        end
        mir_state = '0; mir_img = 1'b0;
        nx = move(7'd0, b);
      end
      if (nx >= 0) begin
        mir_state = 7'(nx);
        if (!(state_flags(mir_state) & A_IGN)) begin
          mir_img = 1'b1;
          add_event(EV_IMAGE, b, TK_NONE, mir_tok_line);
        end
      end else begin
        add_event(EV_INVALID, b, TK_NONE, mir_tok_line);
      end
      if (b == 8'h0a && mir_nl < LMAX) mir_nl++;
      if (state_flags(mir_state) & A_STOP) begin
        add_event(EV_STOP, 8'h00, TK_NONE, mir_tok_line);
        mir_state = '0; mir_img = 1'b0;
        mir_tok_line = line_at(mir_nl);
      end
    end
    if (event_q.size() > n_prior) event_q[event_q.size() - 1].last = 1'b1;
  endtask

  task automatic report_err(string what, int got, int want);
    errors++;
    $display("mismatch at event %0d: %s got %0d expected %0d", events_seen, what, got, want);
  endtask

  // checker: one transaction per accepted result
  always @(posedge clk) begin
    lex_event_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        report_err("unexpected event, event_kind", m_tuser, -1);
      end else begin
        e = event_q.pop_front();
        if (m_tuser !== e.kind) report_err("event_kind", m_tuser, e.kind);
        if (m_tdata[7:0] !== e.ch) report_err("char_out", m_tdata[7:0], e.ch);
        if (m_tdata[12:8] !== e.tk) report_err("token_kind", m_tdata[12:8], e.tk);
        if (m_tdata[28:13] !== e.line) report_err("line_number", m_tdata[28:13], e.line);
        if (m_tdata[31:29] !== 3'b000) report_err("tdata pad", m_tdata[31:29], 0);
        if (m_tlast !== e.last) report_err("last_event", m_tlast, e.last);
      end
      events_seen++;
    end
  end

  // receiver: random stalls per result, plus a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        m_tready = 0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        m_tready = 0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = b;
    s_tuser = eot;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    lex_predict(b, eot);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid = 0;
    while (event_q.size() > 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic write_first_line(logic [15:0] v);
    drain();
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    mir_first = v;
    if (mir_state == 0) mir_tok_line = line_at(mir_nl);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic test_directed();
    send_text(">>>=");
    send_text("$e%%");
    send_text("'\\''");
    send_text("/a\\//g");
    send_text("#x\n");
    send_byte("@", 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("\n1.5");
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);   // end of text with nothing pending
    send_text("\"ab");
    send_byte(8'h00, 1'b1);   // unterminated string
  endtask

  task automatic rand_token();
    string vocab[24] = '{"-", "++", "<<", ">>>", "<=", ">=", "!=", "||", "&&", "|:", "|?",
                        "%%", ":", ",", "(", ")", "[", "]", "{", "}", "$element", "$index",
                        "$key", "$result"};
    int pick;
    int n;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1: send_text(vocab[$urandom_range(0, 23)]);
      2: begin
        if ($urandom_range(0, 1)) send_text("$exception");
        else send_text("$");
      end
      3: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          send_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)), 1'b0);
      end
      4: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 1)) begin
          send_byte(".", 1'b0);
          send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
      end
      5: begin
        send_byte(".", 1'b0);
        send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      6: begin
        send_byte($urandom_range(0, 1) ? "'" : "\"", 1'b0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(32, 126)), 1'b0);
        if ($urandom_range(0, 1)) send_byte("'", 1'b0);
        else send_byte("\"", 1'b0);
      end
      7: begin
        if ($urandom_range(0, 1)) send_text("'''a'b\\'''");
        else send_text("\"\"\"x\"\"\"");
      end
      8: begin
        if ($urandom_range(0, 1)) send_text("/[a\\/]/im");
        else send_text("/ ");
      end
      9: send_text("#note\n");
      10, 11: send_byte($urandom_range(0, 1) ? 8'h0a : " ", 1'b0);
      12: send_byte(8'h09, 1'b0);
      13: send_byte(8'($urandom_range(0, 255)), 1'b0);
      14: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: send_byte(8'h0d, 1'b0);
    endcase
  endtask

  task automatic test_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) no_idle = ~no_idle;
      rand_token();
    end
    no_idle = 0;
  endtask

  task automatic test_pressure();
    hold_req = 300;
    no_idle = 1;
    send_text("$index|: ab12 'q' 3.25\n");
    no_idle = 0;
  endtask

  initial begin
    mir_first = 16'd1;
    mir_state = '0; mir_nl = 0; mir_img = 1'b0;
    mir_tok_line = 16'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_first_line(16'd1);
    test_directed();
    write_first_line(16'd65534);   // line saturates after one newline
    test_random(55);
    test_pressure();
    write_first_line(16'd0);
    test_random(55);
    write_first_line(16'd65535);
    test_random(30);
    write_first_line(16'($urandom_range(0, 65535)));
    test_random(55);
    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d input bytes and %0d lexer events over five first_line settings",
             items_sent, events_seen);
    if (errors == 0 && event_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d events never seen", errors, event_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ script_lexer_dfa.f @@
hdl/sld_pkg.sv
hdl/sld_step.sv
hdl/script_lexer_dfa.sv
dv/tb_script_lexer_dfa.sv
